[hdl/mhpq_pkg.sv]
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared widths, result codes and function codes of the max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

	localparam int VALUE_W = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_OUT_W = 7;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL = 2'd2;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_EXTRACT = 1'b1;

endpackage

`default_nettype wire

[hdl/mhpq_ram.sv]
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

[hdl/max_heap_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// Binary max-heap of signed values kept in one RAM with an entry count.
// Insert sifts the new value up, extract returns the root and sifts the last
// entry down from the root. Full inserts and empty extracts are refused.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------------
//  request  | in        | in_valid / in_stall   | func, value
//  result   | out       | out_valid / out_stall | removed_value, status, count_after
//
// One request at a time: a new request is taken only in the idle state. An
// insert climbs one level at a time and an extract sinks one level at a
// time. Each level costs one registered read of the RAM and one
// compare/write; both children come from the two read ports in the same
// cycle. Reset clears the state, the entry count and the output valid flag;
// the RAM holds no reset state. A stalled result waits in the output
// register while the next request is already taken.
`default_nettype none

module max_heap_priority_queue_unit #(
	parameter int CAPACITY = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 func,
	input  wire logic signed [mhpq_pkg::VALUE_W-1:0]  value,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [mhpq_pkg::VALUE_W-1:0]       removed_value,
	output mhpq_pkg::status_t                         status,
	output logic [mhpq_pkg::COUNT_OUT_W-1:0]          count_after
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CHILD_W = IDX_W + 2;

	typedef enum logic [3:0] {
		IDLE,
		UP_RD,
		UP_CMP,
		EX_RD,
		EX_DAT,
		DN_RD,
		DN_CMP,
		WR,
		FIN
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [IDX_W-1:0]        pos_q;
	logic [DATA_WIDTH-1:0]   v_q;
	logic [DATA_WIDTH-1:0]   removed_q;
	mhpq_pkg::status_t       res_status_q;

	logic                    out_valid_q;
	logic [DATA_WIDTH-1:0]   out_removed_q;
	mhpq_pkg::status_t       out_status_q;
	logic [CNT_W-1:0]        out_count_q;

	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic [DATA_WIDTH-1:0]   ram_wdata;
	logic [IDX_W-1:0]        ram_raddr_a;
	logic [IDX_W-1:0]        ram_raddr_b;
	logic [DATA_WIDTH-1:0]   ram_rdata_a;
	logic [DATA_WIDTH-1:0]   ram_rdata_b;

	logic [IDX_W-1:0]        parent;
	logic [CHILD_W-1:0]      left_c;
	logic [CHILD_W-1:0]      right_c;
	logic                    left_ok;
	logic                    right_ok;
	logic                    pick_right;
	logic [DATA_WIDTH-1:0]   best_val;
	logic [IDX_W-1:0]        best_idx;
	logic                    up_swap;
	logic                    dn_swap;
	logic                    out_free;

	mhpq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.rdata_a (ram_rdata_a),
		.raddr_b (ram_raddr_b),
		.rdata_b (ram_rdata_b)
	);

	assign parent = (pos_q - IDX_W'(1)) >> 1;
	assign left_c = CHILD_W'({pos_q, 1'b1});
	assign right_c = left_c + CHILD_W'(1);
	assign left_ok = left_c < CHILD_W'(cnt_q);
	assign right_ok = right_c < CHILD_W'(cnt_q);

	// left child wins a tie
	assign pick_right = right_ok && ($signed(ram_rdata_b) > $signed(ram_rdata_a));
	assign best_val = pick_right ? ram_rdata_b : ram_rdata_a;
	assign best_idx = pick_right ? right_c[IDX_W-1:0] : left_c[IDX_W-1:0];
	assign dn_swap = $signed(best_val) > $signed(v_q);
	assign up_swap = $signed(v_q) > $signed(ram_rdata_a);

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = v_q;
		ram_raddr_a = parent;
		ram_raddr_b = right_c[IDX_W-1:0];
		unique case (state_q)
			UP_CMP: begin
				ram_we = 1'b1;
				if (up_swap) begin
					ram_wdata = ram_rdata_a;
				end
			end
			EX_RD: begin
				ram_raddr_a = '0;
				ram_raddr_b = cnt_q[IDX_W-1:0];
			end
			DN_RD: begin
				ram_raddr_a = left_c[IDX_W-1:0];
			end
			DN_CMP: begin
				ram_we = 1'b1;
				if (dn_swap) begin
					ram_wdata = best_val;
				end
			end
			WR: begin
				ram_we = 1'b1;
			end
			IDLE, UP_RD, EX_DAT, FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						removed_q <= '0;
						res_status_q <= mhpq_pkg::ST_OK;
						v_q <= DATA_WIDTH'(value);
						if (func == mhpq_pkg::FUNC_INSERT) begin
							if (cnt_q == CNT_W'(CAPACITY)) begin
								res_status_q <= mhpq_pkg::ST_FULL;
								state_q <= FIN;
							end else begin
								pos_q <= cnt_q[IDX_W-1:0];
								cnt_q <= cnt_q + CNT_W'(1);
								state_q <= (cnt_q == '0) ? WR : UP_RD;
							end
						end else begin
							if (cnt_q == '0) begin
								res_status_q <= mhpq_pkg::ST_EMPTY;
								state_q <= FIN;
							end else begin
								pos_q <= '0;
								cnt_q <= cnt_q - CNT_W'(1);
								state_q <= EX_RD;
							end
						end
					end
				end
				UP_RD: begin
					state_q <= UP_CMP;
				end
				UP_CMP: begin
					// parent moves down into the hole, or the value settles here
					if (up_swap) begin
						pos_q <= parent;
						state_q <= (parent == '0) ? WR : UP_RD;
					end else begin
						state_q <= FIN;
					end
				end
				EX_RD: begin
					state_q <= EX_DAT;
				end
				EX_DAT: begin
					removed_q <= ram_rdata_a;
					v_q <= ram_rdata_b;
					state_q <= (cnt_q == '0) ? FIN : DN_RD;
				end
				DN_RD: begin
					state_q <= left_ok ? DN_CMP : WR;
				end
				DN_CMP: begin
					if (dn_swap) begin
						pos_q <= best_idx;
						state_q <= DN_RD;
					end else begin
						state_q <= FIN;
					end
				end
				WR: begin
					state_q <= FIN;
				end
				FIN: begin
					if (out_free) begin
						out_removed_q <= removed_q;
						out_status_q <= res_status_q;
						out_count_q <= cnt_q;
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign in_stall = (state_q != IDLE);
	assign out_valid = out_valid_q;
	assign removed_value = mhpq_pkg::VALUE_W'($signed(out_removed_q));
	assign status = out_status_q;
	assign count_after = mhpq_pkg::COUNT_OUT_W'(out_count_q);

endmodule

`default_nettype wire

[hdl/mhpq_chk.sv]
// ----------------------------------------------------------------------------
// mhpq_chk
// Port-level checks of the max-heap priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_chk #(
	parameter int CAPACITY = 64
) (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_stall,
	input wire logic                                out_valid,
	input wire logic                                out_stall,
	input wire logic signed [mhpq_pkg::VALUE_W-1:0] removed_value,
	input wire mhpq_pkg::status_t                   status,
	input wire logic [mhpq_pkg::COUNT_OUT_W-1:0]    count_after
);

	// a refused extract means the heap was empty and stays so
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mhpq_pkg::ST_EMPTY |-> count_after == '0 && removed_value == '0)
		else $error("empty extract result inconsistent");

	// a refused insert means the heap is at capacity
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mhpq_pkg::ST_FULL
		|-> count_after == mhpq_pkg::COUNT_OUT_W'(CAPACITY) && removed_value == '0)
		else $error("full insert result inconsistent");

	// one request in flight: no request taken while busy the cycle after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted back to back");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(removed_value) && $stable(status)
		&& $stable(count_after))
		else $error("stalled result changed");

endmodule

bind max_heap_priority_queue_unit mhpq_chk #(
	.CAPACITY (CAPACITY)
) u_mhpq_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.removed_value (removed_value),
	.status        (status),
	.count_after   (count_after)
);

`default_nettype wire
